>>> design/tts_pkg.sv
// Shared types and constants for the triangle tangent-space block.
package tts_pkg;

  localparam int VERTEX_INDEX_BITS_DEF = 16;
  localparam int QUEUE_DEPTH           = 2;

  localparam int DELTA_BITS = 33;
  localparam int WIDE_BITS  = 66;
  localparam int MAG_BITS   = 65;
  localparam int Q14_SHIFT  = 14;
  localparam int QUOT_BITS  = 15;
  localparam int OUT_BITS   = 16;
  localparam int FIT_BITS   = 31;

  typedef logic signed [DELTA_BITS-1:0] delta_t;
  typedef logic signed [WIDE_BITS-1:0]  wide_t;
  typedef logic [MAG_BITS-1:0]          mag_t;
  typedef logic signed [OUT_BITS-1:0]   unit_t;

  // edge and texture deltas of one triangle, relative to its first corner
  typedef struct packed {
    delta_t e1x;
    delta_t e1y;
    delta_t e1z;
    delta_t e2x;
    delta_t e2y;
    delta_t e2z;
    delta_t du1;
    delta_t dv1;
    delta_t du2;
    delta_t dv2;
  } tri_delta_t;

  localparam int TRI_DELTA_BITS = $bits(tri_delta_t);

endpackage

>>> design/tts_if.sv
// Vertex and result channel interfaces.
interface tts_vtx_if #(parameter int IW = 16) ();
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] tex_u;
  logic signed [31:0] tex_v;
  logic [IW-1:0]      vertex_index;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, vertex_index,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, vertex_index,
                output ready);
endinterface

interface tts_res_if #(parameter int IW = 16) ();
  logic               valid;
  logic               ready;
  logic signed [15:0] tangent_x;
  logic signed [15:0] tangent_y;
  logic signed [15:0] tangent_z;
  logic signed [15:0] bitangent_x;
  logic signed [15:0] bitangent_y;
  logic signed [15:0] bitangent_z;
  logic [IW-1:0]      corner_a;
  logic [IW-1:0]      corner_b;
  logic [IW-1:0]      corner_c;
  logic               degenerate;

  modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                  bitangent_y, bitangent_z, corner_a, corner_b, corner_c, degenerate,
                  input ready);
  modport sink (input valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                bitangent_y, bitangent_z, corner_a, corner_b, corner_c, degenerate,
                output ready);
endinterface

>>> design/tts_fifo.sv
// Small register queue between the vertex front end and the math back end.
module tts_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  logic [DW-1:0] wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output logic [DW-1:0] rd_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          wr_en, rd_en;

  assign wr_ready = (cnt_r != CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule

>>> design/tts_front.sv
// Front end: holds the first two corners and forms the triangle deltas.
module tts_front #(
  parameter int IW = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  tts_vtx_if.sink             vin,
  output logic                push_valid,
  input  logic                push_ready,
  output tts_pkg::tri_delta_t push_delta,
  output logic [3*IW-1:0]     push_idx
);
  import tts_pkg::*;

  logic [1:0]         cnt_r;
  logic signed [31:0] hp_r [2][3];
  logic signed [31:0] ht_r [2][2];
  logic [IW-1:0]      hi_r [2];
  logic               acc;

  function automatic delta_t dsub(input logic signed [31:0] a, input logic signed [31:0] b);
    dsub = {a[31], a} - {b[31], b};
  endfunction

  assign vin.ready  = (cnt_r != 2'd2) || push_ready;
  assign acc        = vin.valid && vin.ready;
  assign push_valid = vin.valid && (cnt_r == 2'd2);

  assign push_delta.e1x = dsub(hp_r[1][0], hp_r[0][0]);
  assign push_delta.e1y = dsub(hp_r[1][1], hp_r[0][1]);
  assign push_delta.e1z = dsub(hp_r[1][2], hp_r[0][2]);
  assign push_delta.e2x = dsub(vin.pos_x, hp_r[0][0]);
  assign push_delta.e2y = dsub(vin.pos_y, hp_r[0][1]);
  assign push_delta.e2z = dsub(vin.pos_z, hp_r[0][2]);
  assign push_delta.du1 = dsub(ht_r[1][0], ht_r[0][0]);
  assign push_delta.dv1 = dsub(ht_r[1][1], ht_r[0][1]);
  assign push_delta.du2 = dsub(vin.tex_u, ht_r[0][0]);
  assign push_delta.dv2 = dsub(vin.tex_v, ht_r[0][1]);
  assign push_idx       = {hi_r[0], hi_r[1], vin.vertex_index};

  always_ff @(posedge clk) begin
    if (acc && (cnt_r != 2'd2)) begin
      hp_r[cnt_r[0]][0] <= vin.pos_x;
      hp_r[cnt_r[0]][1] <= vin.pos_y;
      hp_r[cnt_r[0]][2] <= vin.pos_z;
      ht_r[cnt_r[0]][0] <= vin.tex_u;
      ht_r[cnt_r[0]][1] <= vin.tex_v;
      hi_r[cnt_r[0]]    <= vin.vertex_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (acc) begin
      cnt_r <= (cnt_r == 2'd2) ? 2'd0 : cnt_r + 2'd1;
    end
  end
endmodule

>>> design/tts_back.sv
// Back end: sequential products, magnitude scaling, square root and division.
module tts_back #(
  parameter int IW = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_valid,
  output logic                rd_ready,
  input  tts_pkg::tri_delta_t rd_delta,
  input  logic [3*IW-1:0]     rd_idx,
  tts_res_if.source           rout
);
  import tts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_LO, S_MUL_HI, S_ACC, S_CHECK, S_LOAD, S_SHIFT,
    S_SQ, S_SQRT, S_DIV_INIT, S_DIV, S_EMIT
  } state_t;

  state_t              state_r;
  tri_delta_t          d_r;
  logic [3*IW-1:0]     idx_r;
  logic [3:0]          term_r;
  wide_t               acc_r [7];
  logic [48:0]         plo_r;
  logic [49:0]         phi_r;
  logic                pneg_r;
  logic                vec_r;
  mag_t                m_r [3];
  logic                neg_r [3];
  logic [1:0]          sqc_r;
  logic [61:0]         sq_r;
  logic [63:0]         sum_r, sx_r, sr_r, sb_r;
  logic [31:0]         n_r;
  logic [1:0]          comp_r;
  logic [3:0]          dbit_r;
  logic [46:0]         rem_r;
  logic [QUOT_BITS-1:0] q_r;
  unit_t               res_r [6];
  logic                degen_r;
  logic                ovalid_r;

  delta_t              op_a, op_b;
  logic                op_neg;
  logic [32:0]         am, bm;
  mag_t                prod;
  logic                big;
  logic [30:0]         sq_in;
  logic [63:0]         trial;
  logic [46:0]         cand;
  logic                hit;
  logic [QUOT_BITS-1:0] qn;
  logic [30:0]         m_comp;
  logic [2:0]          ridx;

  // term sequence: det, then tangent components, then bitangent components
  always_comb begin
    case (term_r)
      4'd0:    begin op_a = d_r.du1; op_b = d_r.dv2; end
      4'd1:    begin op_a = d_r.du2; op_b = d_r.dv1; end
      4'd2:    begin op_a = d_r.e1x; op_b = d_r.dv2; end
      4'd3:    begin op_a = d_r.e2x; op_b = d_r.dv1; end
      4'd4:    begin op_a = d_r.e1y; op_b = d_r.dv2; end
      4'd5:    begin op_a = d_r.e2y; op_b = d_r.dv1; end
      4'd6:    begin op_a = d_r.e1z; op_b = d_r.dv2; end
      4'd7:    begin op_a = d_r.e2z; op_b = d_r.dv1; end
      4'd8:    begin op_a = d_r.e2x; op_b = d_r.du1; end
      4'd9:    begin op_a = d_r.e1x; op_b = d_r.du2; end
      4'd10:   begin op_a = d_r.e2y; op_b = d_r.du1; end
      4'd11:   begin op_a = d_r.e1y; op_b = d_r.du2; end
      4'd12:   begin op_a = d_r.e2z; op_b = d_r.du1; end
      4'd13:   begin op_a = d_r.e1z; op_b = d_r.du2; end
      default: begin op_a = '0;      op_b = '0;      end
    endcase
  end

  // odd terms subtract; a negative determinant flips T and B
  assign op_neg = op_a[32] ^ op_b[32] ^ term_r[0] ^ ((term_r > 4'd1) && acc_r[0][WIDE_BITS-1]);
  assign am     = op_a[32] ? 33'(-op_a) : 33'(op_a);
  assign bm     = op_b[32] ? 33'(-op_b) : 33'(op_b);
  assign prod   = MAG_BITS'(plo_r) + (MAG_BITS'(phi_r) << 16);

  assign big = (m_r[0][MAG_BITS-1:FIT_BITS] != '0) || (m_r[1][MAG_BITS-1:FIT_BITS] != '0) ||
               (m_r[2][MAG_BITS-1:FIT_BITS] != '0);

  assign sq_in  = (sqc_r == 2'd0) ? m_r[0][30:0] :
                  (sqc_r == 2'd1) ? m_r[1][30:0] : m_r[2][30:0];
  assign m_comp = (comp_r == 2'd0) ? m_r[0][30:0] :
                  (comp_r == 2'd1) ? m_r[1][30:0] : m_r[2][30:0];

  assign trial = sr_r + sb_r;
  assign cand  = 47'(n_r) << dbit_r;
  assign hit   = (n_r != '0) && (rem_r >= cand);
  assign qn    = hit ? (q_r | (QUOT_BITS'(1) << dbit_r)) : q_r;
  assign ridx  = vec_r ? 3'd3 + 3'(comp_r) : 3'(comp_r);

  assign rd_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      // a reload in S_EMIT takes over the clear of a drained result
      if (ovalid_r && rout.ready && (state_r != S_EMIT)) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (rd_valid) begin
            d_r     <= rd_delta;
            idx_r   <= rd_idx;
            term_r  <= 4'd0;
            degen_r <= 1'b0;
            vec_r   <= 1'b0;
            for (int k = 0; k < 7; k++) acc_r[k] <= '0;
            for (int k = 0; k < 6; k++) res_r[k] <= '0;
            state_r <= S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          plo_r   <= am * bm[15:0];
          pneg_r  <= op_neg;
          state_r <= S_MUL_HI;
        end
        S_MUL_HI: begin
          phi_r   <= am * bm[32:16];
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r[term_r[3:1]] <= pneg_r ? acc_r[term_r[3:1]] - {1'b0, prod}
                                       : acc_r[term_r[3:1]] + {1'b0, prod};
          term_r <= term_r + 4'd1;
          if (term_r == 4'd1) begin
            state_r <= S_CHECK;
          end else if (term_r == 4'd13) begin
            state_r <= S_LOAD;
          end else begin
            state_r <= S_MUL_LO;
          end
        end
        S_CHECK: begin
          if (acc_r[0] == '0) begin
            degen_r <= 1'b1;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_MUL_LO;
          end
        end
        S_LOAD: begin
          for (int k = 0; k < 3; k++) begin
            neg_r[k] <= acc_r[(vec_r ? 4 : 1) + k][WIDE_BITS-1];
            m_r[k]   <= acc_r[(vec_r ? 4 : 1) + k][WIDE_BITS-1] ?
                        MAG_BITS'(-acc_r[(vec_r ? 4 : 1) + k]) :
                        MAG_BITS'(acc_r[(vec_r ? 4 : 1) + k]);
          end
          state_r <= S_SHIFT;
        end
        S_SHIFT: begin
          // truncating shifts compose, so one bit a cycle reaches the common shift
          if (big) begin
            for (int k = 0; k < 3; k++) m_r[k] <= m_r[k] >> 1;
          end else begin
            sqc_r   <= 2'd0;
            sum_r   <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (sqc_r != 2'd3) begin
            sq_r <= sq_in * sq_in;
          end
          if (sqc_r != 2'd0) begin
            sum_r <= sum_r + 64'(sq_r);
          end
          sqc_r <= sqc_r + 2'd1;
          if (sqc_r == 2'd3) begin
            sx_r    <= sum_r + 64'(sq_r);
            sr_r    <= '0;
            sb_r    <= 64'd1 << 62;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sb_r == '0) begin
            n_r     <= sr_r[31:0];
            comp_r  <= 2'd0;
            state_r <= S_DIV_INIT;
          end else begin
            if (sx_r >= trial) begin
              sx_r <= sx_r - trial;
              sr_r <= (sr_r >> 1) + sb_r;
            end else begin
              sr_r <= sr_r >> 1;
            end
            sb_r <= sb_r >> 2;
          end
        end
        S_DIV_INIT: begin
          rem_r   <= (n_r == '0) ? '0 :
                     ({2'b0, m_comp, 14'b0} + 47'(n_r >> 1));
          q_r     <= '0;
          dbit_r  <= 4'(Q14_SHIFT);
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (hit) begin
            rem_r <= rem_r - cand;
          end
          q_r    <= qn;
          dbit_r <= dbit_r - 4'd1;
          if (dbit_r == 4'd0) begin
            res_r[ridx] <= neg_r[comp_r] ? unit_t'(-{1'b0, qn}) : unit_t'({1'b0, qn});
            if (comp_r == 2'd2) begin
              if (!vec_r) begin
                vec_r   <= 1'b1;
                state_r <= S_LOAD;
              end else begin
                state_r <= S_EMIT;
              end
            end else begin
              comp_r  <= comp_r + 2'd1;
              state_r <= S_DIV_INIT;
            end
          end
        end
        S_EMIT: begin
          if (!ovalid_r || rout.ready) begin
            ovalid_r         <= 1'b1;
            rout.tangent_x   <= res_r[0];
            rout.tangent_y   <= res_r[1];
            rout.tangent_z   <= res_r[2];
            rout.bitangent_x <= res_r[3];
            rout.bitangent_y <= res_r[4];
            rout.bitangent_z <= res_r[5];
            rout.corner_a    <= idx_r[3*IW-1:2*IW];
            rout.corner_b    <= idx_r[2*IW-1:IW];
            rout.corner_c    <= idx_r[IW-1:0];
            rout.degenerate  <= degen_r;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rout.valid = ovalid_r;
endmodule

>>> design/triangle_tangent_space.sv
// Triangle tangent-space unit: top level.
// Vertices of indexed triangles are taken one per cycle; every third vertex
// completes a triangle, whose deltas go into a two-entry queue. The back end
// works on one triangle at a time with a shared 33x17 multiplier (fourteen
// products, each formed in two halves and accumulated), a one-bit-a-cycle
// scaling shift, a 32-step square root and a 15-step divider per output
// component. A zero UV determinant ends a triangle early as degenerate. The
// third vertex of a triangle waits while the queue is full; a finished
// result waits in an output register without stopping new work.
module triangle_tangent_space #(
  parameter int VERTEX_INDEX_BITS = tts_pkg::VERTEX_INDEX_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  tts_vtx_if.sink    in_ch,
  tts_res_if.source  out_ch
);
  import tts_pkg::*;

  localparam int IW = VERTEX_INDEX_BITS;
  localparam int DW = TRI_DELTA_BITS + 3 * IW;

  logic            push_valid, push_ready, pop_valid, pop_ready;
  tri_delta_t      push_delta, pop_delta;
  logic [3*IW-1:0] push_idx, pop_idx;
  logic [DW-1:0]   pop_data;

  tts_front #(.IW(IW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .vin        (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_delta (push_delta),
    .push_idx   (push_idx)
  );

  tts_fifo #(.DW(DW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_delta, push_idx}),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  assign pop_delta = pop_data[DW-1:3*IW];
  assign pop_idx   = pop_data[3*IW-1:0];

  tts_back #(.IW(IW)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_delta (pop_delta),
    .rd_idx   (pop_idx),
    .rout     (out_ch)
  );
endmodule
